FILE: rtl/core/ble_pkg.sv
`default_nettype none
package ble_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_COUNT      = 3'd5,
    ACT_LIST       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ED_NONE,
    ED_PUSH_FRONT,
    ED_PUSH_BACK,
    ED_POP_FRONT,
    ED_POP_BACK,
    ED_CNT_INIT,
    ED_DEL_STEP,
    ED_LIST_STEP
  } edit_t;

  typedef enum logic [1:0] {
    ITEM_ZERO,
    ITEM_HEAD,
    ITEM_TAIL
  } item_sel_t;

  typedef struct packed {
    logic      capture;
    edit_t     edit;
    logic      emit;
    item_sel_t item_sel;
    logic      rem_en;
    status_t   status;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/bounded_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit words, front at index 0.
// Input channel (in_valid/in_ready): one transfer carries an action and a
// value: push front/back, pop front/back, delete all equal to value, count,
// or list. Output channel (out_valid/out_ready): one result per action, or
// one per entry for a list of a non-empty list, last set on the final one.
// Every result reports the entry count left after the action.
// Timing: an item is taken in the idle state and executed in the exec state,
// which waits until the output register is free; no new item is taken until
// the last one has executed. Delete walks the entry chain one entry a cycle,
// then posts its result. Listing rotates the chain and sends one entry a cycle
// while the output register is free.
// A result sits in an output register, so the next item is taken while it
// waits. When the receiver stalls, results hold and execution waits until
// the output register frees.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared.
`default_nettype none
module bounded_list_engine #(
  parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_action,
  input  wire logic signed [ble_pkg::VAL_W-1:0]  in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ble_pkg::VAL_W-1:0]       out_item_value,
  output logic [ble_pkg::CNT_W-1:0]              out_entry_count,
  output logic [ble_pkg::CNT_W-1:0]              out_removed,
  output logic [1:0]                             out_status,
  output logic                                   out_last
);

  ble_pkg::dp_cmd_t  cmd;
  ble_pkg::dp_stat_t stat;

  ble_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd)
  );

  ble_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_value  (out_item_value),
    .out_entry_count (out_entry_count),
    .out_removed     (out_removed),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ble_datapath.sv
`default_nettype none
module ble_datapath #(
  parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ble_pkg::dp_cmd_t                  cmd,
  output ble_pkg::dp_stat_t                      stat,
  input  wire logic signed [ble_pkg::VAL_W-1:0]  in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ble_pkg::VAL_W-1:0]       out_item_value,
  output logic [ble_pkg::CNT_W-1:0]              out_entry_count,
  output logic [ble_pkg::CNT_W-1:0]              out_removed,
  output logic [1:0]                             out_status,
  output logic                                   out_last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [ble_pkg::VAL_W-1:0] entries_r   [DEPTH];
  logic signed [ble_pkg::VAL_W-1:0] entries_nxt [DEPTH];
  logic [CW-1:0]                    occ_r, occ_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    start_r, start_nxt;
  logic signed [ble_pkg::VAL_W-1:0] val_r;

  logic                             out_valid_r;
  logic signed [ble_pkg::VAL_W-1:0] item_r;
  logic [ble_pkg::CNT_W-1:0]        count_r;
  logic [ble_pkg::CNT_W-1:0]        removed_r;
  logic [1:0]                       status_r;
  logic                             last_r;

  logic [CW-1:0]                    occ_m1;
  logic                             keep;
  logic signed [ble_pkg::VAL_W-1:0] tail;
  logic signed [ble_pkg::VAL_W-1:0] item_sel;
  logic [CW-1:0]                    removed_full;

  assign occ_m1       = occ_r - CW'(1);
  assign keep         = (entries_r[0] != val_r);
  assign tail         = entries_r[occ_m1[IW-1:0]];
  assign removed_full = start_r - occ_r;

  assign stat.empty    = (occ_r == '0);
  assign stat.full     = (occ_r >= CW'(DEPTH));
  assign stat.cnt_last = (cnt_r == CW'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    occ_nxt   = occ_r;
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    for (int i = 0; i < DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    unique case (cmd.edit)
      ble_pkg::ED_PUSH_FRONT: begin
        entries_nxt[0] = val_r;
        for (int i = 1; i < DEPTH; i++) begin
          entries_nxt[i] = entries_r[i-1];
        end
        occ_nxt = occ_r + CW'(1);
      end
      ble_pkg::ED_PUSH_BACK: begin
        entries_nxt[occ_r[IW-1:0]] = val_r;
        occ_nxt = occ_r + CW'(1);
      end
      ble_pkg::ED_POP_FRONT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          entries_nxt[i] = entries_r[i+1];
        end
        occ_nxt = occ_m1;
      end
      ble_pkg::ED_POP_BACK: begin
        occ_nxt = occ_m1;
      end
      ble_pkg::ED_CNT_INIT: begin
        cnt_nxt   = occ_r;
        start_nxt = occ_r;
      end
      ble_pkg::ED_DEL_STEP, ble_pkg::ED_LIST_STEP: begin
        // rotate the head to the tail of the live span, or drop it on a match
        for (int i = 0; i < DEPTH - 1; i++) begin
          entries_nxt[i] = entries_r[i+1];
        end
        if (cmd.edit == ble_pkg::ED_LIST_STEP || keep) begin
          entries_nxt[occ_m1[IW-1:0]] = entries_r[0];
        end else begin
          occ_nxt = occ_m1;
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cmd.item_sel)
      ble_pkg::ITEM_HEAD: item_sel = entries_r[0];
      ble_pkg::ITEM_TAIL: item_sel = tail;
      default:            item_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
    cnt_r   <= cnt_nxt;
    start_r <= start_nxt;
    if (cmd.capture) begin
      val_r <= in_value;
    end
    if (cmd.emit) begin
      item_r    <= item_sel;
      count_r   <= ble_pkg::CNT_W'(occ_nxt);
      removed_r <= cmd.rem_en ? ble_pkg::CNT_W'(removed_full) : '0;
      status_r  <= cmd.status;
      last_r    <= cmd.last;
    end
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_value  = item_r;
  assign out_entry_count = count_r;
  assign out_removed     = removed_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

FILE: rtl/core/ble_ctrl.sv
`default_nettype none
module ble_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_action,
  input  wire ble_pkg::dp_stat_t stat,
  output ble_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL,
    S_DEL_DONE,
    S_LIST
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] act_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.edit     = ble_pkg::ED_NONE;
    cmd.emit     = 1'b0;
    cmd.item_sel = ble_pkg::ITEM_ZERO;
    cmd.rem_en   = 1'b0;
    cmd.status   = ble_pkg::ST_OK;
    cmd.last     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the output register can take a result
        if (stat.out_free) begin
          state_nxt = S_IDLE;
          unique case (act_r)
            ble_pkg::ACT_PUSH_FRONT, ble_pkg::ACT_PUSH_BACK: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.status = ble_pkg::ST_FULL;
              end else begin
                cmd.edit = (act_r == ble_pkg::ACT_PUSH_FRONT) ?
                           ble_pkg::ED_PUSH_FRONT : ble_pkg::ED_PUSH_BACK;
              end
            end
            ble_pkg::ACT_POP_FRONT, ble_pkg::ACT_POP_BACK: begin
              cmd.emit = 1'b1;
              if (stat.empty) begin
                cmd.status = ble_pkg::ST_EMPTY;
              end else if (act_r == ble_pkg::ACT_POP_FRONT) begin
                cmd.edit     = ble_pkg::ED_POP_FRONT;
                cmd.item_sel = ble_pkg::ITEM_HEAD;
              end else begin
                cmd.edit     = ble_pkg::ED_POP_BACK;
                cmd.item_sel = ble_pkg::ITEM_TAIL;
              end
            end
            ble_pkg::ACT_DELETE, ble_pkg::ACT_LIST: begin
              if (stat.empty) begin
                cmd.emit   = 1'b1;
                cmd.status = ble_pkg::ST_EMPTY;
              end else begin
                cmd.edit  = ble_pkg::ED_CNT_INIT;
                state_nxt = (act_r == ble_pkg::ACT_DELETE) ? S_DEL : S_LIST;
              end
            end
            ble_pkg::ACT_COUNT: begin
              cmd.emit = 1'b1;
            end
            default: begin
              // reserved selector: drop the item
            end
          endcase
        end
      end
      S_DEL: begin
        cmd.edit = ble_pkg::ED_DEL_STEP;
        if (stat.cnt_last) begin
          state_nxt = S_DEL_DONE;
        end
      end
      S_DEL_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.rem_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.edit     = ble_pkg::ED_LIST_STEP;
          cmd.emit     = 1'b1;
          cmd.item_sel = ble_pkg::ITEM_HEAD;
          cmd.last     = stat.cnt_last;
          if (stat.cnt_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= ble_pkg::ACT_COUNT;
    end else begin
      state_r <= state_nxt;
      if (cmd.capture) begin
        act_r <= in_action;
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/bounded_list_engine_tb.sv
`default_nettype none
module bounded_list_engine_tb;

  localparam int          LIST_DEPTH = ble_pkg::DEPTH_DEF;
  localparam logic [2:0]  ACT_UNUSED = 3'd7;
  localparam int          ITEMS_PER_PHASE = 55;
  localparam int          DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [ble_pkg::VAL_W-1:0] item_value;
    logic [ble_pkg::CNT_W-1:0]        entry_count;
    logic [ble_pkg::CNT_W-1:0]        removed;
    ble_pkg::status_t                 status;
    logic                             last;
  } list_result_t;

  // Mirror of the list contents and the results still owed by the block.
  class list_scoreboard;
    logic signed [ble_pkg::VAL_W-1:0] ents [LIST_DEPTH];
    int unsigned                      occ;
    list_result_t                     owed_q [$];
    int unsigned                      errors;

    function new();
      occ = 0;
      errors = 0;
    endfunction

    function void owe(logic signed [ble_pkg::VAL_W-1:0] item, int unsigned rem,
                      ble_pkg::status_t st, logic lst);
      list_result_t r;
      r.item_value  = item;
      r.entry_count = ble_pkg::CNT_W'(occ);
      r.removed     = ble_pkg::CNT_W'(rem);
      r.status      = st;
      r.last        = lst;
      owed_q.push_back(r);
    endfunction

    function void note_input(logic [2:0] act, logic signed [ble_pkg::VAL_W-1:0] val);
      int unsigned                      w;
      logic signed [ble_pkg::VAL_W-1:0] item;
      case (act)
        ble_pkg::ACT_PUSH_FRONT, ble_pkg::ACT_PUSH_BACK: begin
          if (occ >= LIST_DEPTH) begin
            owe('0, 0, ble_pkg::ST_FULL, 1'b1);
          end else begin
            if (act == ble_pkg::ACT_PUSH_FRONT) begin
              for (int i = occ; i > 0; i--) ents[i] = ents[i-1];
              ents[0] = val;
            end else begin
              ents[occ] = val;
            end
            occ++;
            owe('0, 0, ble_pkg::ST_OK, 1'b1);
          end
        end
        ble_pkg::ACT_POP_FRONT, ble_pkg::ACT_POP_BACK: begin
          if (occ == 0) begin
            owe('0, 0, ble_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (act == ble_pkg::ACT_POP_FRONT) begin
              item = ents[0];
              for (int i = 0; i + 1 < occ; i++) ents[i] = ents[i+1];
            end else begin
              item = ents[occ-1];
            end
            occ--;
            owe(item, 0, ble_pkg::ST_OK, 1'b1);
          end
        end
        ble_pkg::ACT_DELETE: begin
          if (occ == 0) begin
            owe('0, 0, ble_pkg::ST_EMPTY, 1'b1);
          end else begin
            // compact the survivors towards the front, keeping their order
            w = 0;
            for (int i = 0; i < occ; i++) begin
              if (ents[i] !== val) begin
                ents[w] = ents[i];
                w++;
              end
            end
            item = '0;
            w = occ - w;
            occ = occ - w;
            owe(item, w, ble_pkg::ST_OK, 1'b1);
          end
        end
        ble_pkg::ACT_COUNT: owe('0, 0, ble_pkg::ST_OK, 1'b1);
        ble_pkg::ACT_LIST: begin
          if (occ == 0) begin
            owe('0, 0, ble_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < occ; i++) owe(ents[i], 0, ble_pkg::ST_OK, (i + 1 == occ));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [ble_pkg::VAL_W-1:0] item,
                               logic [ble_pkg::CNT_W-1:0] cnt,
                               logic [ble_pkg::CNT_W-1:0] rem, logic [1:0] st, logic lst);
      list_result_t exp_r;
      if (owed_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: item %0d count %0d removed %0d status %0d last %0d",
                   item, cnt, rem, st, lst);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (item !== exp_r.item_value || cnt !== exp_r.entry_count ||
          rem !== exp_r.removed || st !== exp_r.status || lst !== exp_r.last) begin
        if (errors < 10) begin
          $display("result differs: expected item %0d count %0d removed %0d status %0d last %0d",
                   exp_r.item_value, exp_r.entry_count, exp_r.removed, exp_r.status,
                   exp_r.last);
          $display("                got item %0d count %0d removed %0d status %0d last %0d",
                   item, cnt, rem, st, lst);
        end
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [2:0]                       in_action = '0;
  logic signed [ble_pkg::VAL_W-1:0] in_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [ble_pkg::VAL_W-1:0] out_item_value;
  logic [ble_pkg::CNT_W-1:0]        out_entry_count;
  logic [ble_pkg::CNT_W-1:0]        out_removed;
  logic [1:0]                       out_status;
  logic                             out_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  list_scoreboard sb = new();

  bounded_list_engine u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_value  (out_item_value),
    .out_entry_count (out_entry_count),
    .out_removed     (out_removed),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_item_value, out_entry_count, out_removed, out_status, out_last);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [2:0] act,
                           input logic signed [ble_pkg::VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, val);
    @(negedge clk);
  endtask

  task automatic pick_item(input int mode, output logic [2:0] act,
                           output logic signed [ble_pkg::VAL_W-1:0] val);
    logic signed [ble_pkg::VAL_W-1:0] pool [4];
    int unsigned                      r;
    int unsigned                      v;
    pool[0] = 32'sd3;
    pool[1] = -32'sd3;
    pool[2] = 32'h7fff_ffff;
    pool[3] = 32'h8000_0000;
    r = $urandom_range(0, 99);
    case (mode)
      0: act = (r < 45) ? ble_pkg::ACT_PUSH_FRONT : (r < 85) ? ble_pkg::ACT_PUSH_BACK :
               3'($urandom_range(0, 7));
      1: act = (r < 3) ? ACT_UNUSED : 3'($urandom_range(0, 6));
      2: act = (r < 30) ? ble_pkg::ACT_POP_FRONT : (r < 60) ? ble_pkg::ACT_POP_BACK :
               (r < 80) ? ble_pkg::ACT_DELETE : 3'($urandom_range(0, 7));
      default: act = (r < 30) ? ble_pkg::ACT_LIST : (r < 50) ? ble_pkg::ACT_DELETE :
                     (r < 75) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
    endcase
    // favour values already held so that deletes find matches, often several
    v = $urandom_range(0, 99);
    if (sb.occ > 0 && v < 35)
      val = sb.ents[$urandom_range(0, sb.occ - 1)];
    else if (v < 60)
      val = pool[$urandom_range(0, 3)];
    else
      val = $urandom();
  endtask

  initial begin
    logic [2:0]                       act;
    logic signed [ble_pkg::VAL_W-1:0] val;
    int                               n;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corners
    send_item(ble_pkg::ACT_POP_FRONT, 32'sd0);
    send_item(ble_pkg::ACT_POP_BACK, 32'sd0);
    send_item(ble_pkg::ACT_DELETE, 32'sd0);
    send_item(ble_pkg::ACT_LIST, 32'sd0);
    send_item(ble_pkg::ACT_COUNT, 32'sd0);
    send_item(ACT_UNUSED, 32'sd17);
    // pop back of a single entry
    send_item(ble_pkg::ACT_PUSH_BACK, 32'sd42);
    send_item(ble_pkg::ACT_POP_BACK, 32'sd0);
    send_item(ble_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_item(ble_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    send_item(ble_pkg::ACT_PUSH_FRONT, -32'sd1);
    send_item(ble_pkg::ACT_PUSH_BACK, 32'sd5);
    send_item(ble_pkg::ACT_PUSH_BACK, 32'sd5);
    send_item(ble_pkg::ACT_PUSH_BACK, -32'sd1);
    send_item(ble_pkg::ACT_PUSH_BACK, 32'sd5);
    send_item(ble_pkg::ACT_LIST, 32'sd0);
    // adjacent and tail matches, then front and tail, then none
    send_item(ble_pkg::ACT_DELETE, 32'sd5);
    send_item(ble_pkg::ACT_DELETE, -32'sd1);
    send_item(ble_pkg::ACT_DELETE, 32'sd123);
    send_item(ble_pkg::ACT_COUNT, 32'sd0);
    send_item(ble_pkg::ACT_POP_FRONT, 32'sd0);
    send_item(ble_pkg::ACT_LIST, 32'sd0);
    send_item(ble_pkg::ACT_POP_BACK, 32'sd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick_item((n / 14) % 4, act, val);
        send_item(act, val);
        if (act != ACT_UNUSED) n++;
      end
    end
    in_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("bounded_list_engine: match");
    end else begin
      $display("bounded_list_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("bounded_list_engine: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/ble_pkg.sv
rtl/core/ble_datapath.sv
rtl/core/ble_ctrl.sv
rtl/core/bounded_list_engine.sv
tb/sv/bounded_list_engine_tb.sv
